/* rtl/core/iocrob_pkg.sv */
`timescale 1ns / 1ps

package iocrob_pkg;

  localparam int unsigned CNT_W    = 7;
  localparam int unsigned SRC_W    = 6;
  localparam int unsigned GRP_W    = 6;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned IN_DW    = 48;
  localparam int unsigned OUT_DW   = 48;
  localparam int unsigned MAX_IDX  = 64;

  typedef enum logic [REQ_W-1:0] {
    REQ_BEGIN = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // controller to datapath
  typedef struct packed {
    logic start_round;
    logic store;
    logic set_skip;
    logic clr_skip;
    logic rd_en;
    logic advance;
    logic take;
    logic push;
    logic push_last;
  } iocrob_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_ok;
    logic at_end;
    logic cur_filled;
    logic skip;
    logic rd_nonempty;
    logic pend_valid;
    logic out_free;
  } iocrob_sts_t;

endpackage

/* rtl/core/iocrob_ctrl.sv */
`timescale 1ns / 1ps

module iocrob_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [iocrob_pkg::REQ_W-1:0] in_req_i,
  output logic                         in_ready_o,
  input  iocrob_pkg::iocrob_sts_t      sts_i,
  output iocrob_pkg::iocrob_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_READ = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (iocrob_pkg::req_e'(in_req_i))
            iocrob_pkg::REQ_BEGIN: begin
              cmd_o.start_round = 1'b1;
            end
            iocrob_pkg::REQ_ADD: begin
              if (sts_i.idx_ok) begin
                cmd_o.store    = 1'b1;
                cmd_o.clr_skip = 1'b1;
                state_d        = S_SCAN;
              end
            end
            iocrob_pkg::REQ_FLUSH: begin
              cmd_o.set_skip = 1'b1;
              state_d        = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (sts_i.at_end || (!sts_i.cur_filled && !sts_i.skip)) begin
          state_d = S_FIN;
        end else if (!sts_i.cur_filled) begin
          cmd_o.advance = 1'b1;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        if (!sts_i.rd_nonempty) begin
          cmd_o.advance = 1'b1;
          state_d       = S_SCAN;
        end else if (!sts_i.pend_valid) begin
          cmd_o.take    = 1'b1;
          cmd_o.advance = 1'b1;
          state_d       = S_SCAN;
        end else if (sts_i.out_free) begin
          cmd_o.push    = 1'b1;
          cmd_o.take    = 1'b1;
          cmd_o.advance = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_FIN: begin
        if (!sts_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/iocrob_dp.sv */
`timescale 1ns / 1ps

module iocrob_dp #(
  parameter int unsigned DEPTH   = 64,
  parameter int unsigned STORE_W = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [iocrob_pkg::IN_DW-1:0]  in_data_i,
  input  iocrob_pkg::iocrob_cmd_t       cmd_i,
  output iocrob_pkg::iocrob_sts_t       sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [iocrob_pkg::OUT_DW-1:0] out_data_o,
  output logic                          out_last_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [iocrob_pkg::CNT_W-1:0] in_count;
  logic [iocrob_pkg::SRC_W-1:0] in_idx;
  logic [iocrob_pkg::TAG_W-1:0] in_tag;
  logic                         in_has;

  assign in_count = in_data_i[6:0];
  assign in_idx   = in_data_i[12:7];
  assign in_tag   = in_data_i[44:13];
  assign in_has   = in_data_i[45];

  logic [DEPTH-1:0]             filled_q, filled_d;
  logic [iocrob_pkg::CNT_W-1:0] cursor_q, cursor_d;
  logic [iocrob_pkg::CNT_W-1:0] expected_q, expected_d;
  logic [iocrob_pkg::CNT_W-1:0] emitted_q, emitted_d;
  logic                         skip_q, skip_d;
  logic                         pend_valid_q, pend_valid_d;
  logic [STORE_W-1:0]           pend_tag_q;
  logic [iocrob_pkg::SRC_W-1:0] pend_src_q;
  logic [iocrob_pkg::GRP_W-1:0] pend_grp_q;
  logic                         out_valid_q, out_valid_d;
  logic [iocrob_pkg::TAG_W-1:0] out_tag_q;
  logic [iocrob_pkg::SRC_W-1:0] out_src_q;
  logic [iocrob_pkg::GRP_W-1:0] out_grp_q;
  logic                         out_last_q;

  // tag and nonempty flag per slot
  logic [STORE_W:0]   slot_mem [DEPTH];
  logic [STORE_W:0]   rd_q;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;
  logic               out_free;

  assign wr_addr  = in_idx[IDX_W-1:0];
  assign rd_addr  = cursor_q[IDX_W-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      slot_mem[wr_addr] <= {in_has, in_tag[STORE_W-1:0]};
    end
    if (cmd_i.rd_en) begin
      rd_q <= slot_mem[rd_addr];
    end
  end

  always_comb begin
    filled_d     = filled_q;
    cursor_d     = cursor_q;
    expected_d   = expected_q;
    emitted_d    = emitted_q;
    skip_d       = skip_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q;
    if (cmd_i.start_round) begin
      filled_d   = '0;
      cursor_d   = '0;
      emitted_d  = '0;
      expected_d = (int'(in_count) > int'(DEPTH)) ? iocrob_pkg::CNT_W'(DEPTH) : in_count;
    end
    if (cmd_i.store) begin
      filled_d[wr_addr] = 1'b1;
    end
    if (cmd_i.set_skip) begin
      skip_d = 1'b1;
    end
    if (cmd_i.clr_skip) begin
      skip_d = 1'b0;
    end
    if (cmd_i.advance) begin
      cursor_d = cursor_q + iocrob_pkg::CNT_W'(1);
    end
    if (cmd_i.take) begin
      emitted_d = emitted_q + iocrob_pkg::CNT_W'(1);
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.push) begin
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end
    if (cmd_i.take) begin
      pend_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q     <= '0;
      cursor_q     <= '0;
      expected_q   <= '0;
      emitted_q    <= '0;
      skip_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      filled_q     <= filled_d;
      cursor_q     <= cursor_d;
      expected_q   <= expected_d;
      emitted_q    <= emitted_d;
      skip_q       <= skip_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pend_tag_q <= rd_q[STORE_W-1:0];
      pend_src_q <= cursor_q[iocrob_pkg::SRC_W-1:0];
      pend_grp_q <= emitted_q[iocrob_pkg::GRP_W-1:0];
    end
    if (cmd_i.push) begin
      out_tag_q  <= iocrob_pkg::TAG_W'(pend_tag_q);
      out_src_q  <= pend_src_q;
      out_grp_q  <= pend_grp_q;
      out_last_q <= cmd_i.push_last;
    end
  end

  assign sts_o.idx_ok      = {1'b0, in_idx} < expected_q;
  assign sts_o.at_end      = cursor_q >= expected_q;
  assign sts_o.cur_filled  = filled_q[rd_addr];
  assign sts_o.skip        = skip_q;
  assign sts_o.rd_nonempty = rd_q[STORE_W];
  assign sts_o.pend_valid  = pend_valid_q;
  assign sts_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {4'b0000, out_grp_q, out_src_q, out_tag_q};

endmodule

/* rtl/core/in_order_completion_reorder_buffer_core.sv */
`timescale 1ns / 1ps
// reorder buffer for completions that arrive out of order
// input channel s_axis: one word is a request, tuser gives its kind
//   (begin round, add completed slot, flush remaining slots)
// output channel m_axis: one word per emitted group in slot order, with
//   tlast on the final word caused by a request
// begin gives no words; an add or flush walks the slots from the commit
//   cursor after the request word, reading each filled slot through the
//   one slot memory read port; an add stops at the first missing slot, a
//   flush skips missing slots; the walk ends with the end check and finish
// one request is worked on at a time; s_axis_tready_o is high between
//   requests, also while the last output word still waits to be taken
// a finished word waits in the output register while m_axis_tready_i is
//   low; the walk stalls until it moves on, no word is lost
// reset clears all filled bits, the cursor, the expected count and the
//   group counter at once; the slot memory needs no clearing
module in_order_completion_reorder_buffer_core #(
  parameter int unsigned SLOTS    = 64,
  parameter int unsigned TAG_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // expected_count, slot_index, group_tag, group_has_matches, zero pad
  input  logic [iocrob_pkg::IN_DW-1:0]  s_axis_tdata_i,
  // req_type
  input  logic [iocrob_pkg::REQ_W-1:0]  s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // out_tag, out_source_index, out_group_number, zero pad
  output logic [iocrob_pkg::OUT_DW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);

  localparam int unsigned DEPTH   = (SLOTS < iocrob_pkg::MAX_IDX) ? SLOTS
                                                                  : iocrob_pkg::MAX_IDX;
  localparam int unsigned STORE_W = (TAG_BITS < iocrob_pkg::TAG_W) ? TAG_BITS
                                                                   : iocrob_pkg::TAG_W;

  iocrob_pkg::iocrob_cmd_t cmd;
  iocrob_pkg::iocrob_sts_t sts;

  iocrob_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_req_i   (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iocrob_dp #(
    .DEPTH   (DEPTH),
    .STORE_W (STORE_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !sts.pend_valid)
    else $error("pending group left behind between requests");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> sts.out_free)
    else $error("output word overwritten");

  a_take_in_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take |-> !sts.at_end)
    else $error("group taken beyond expected slots");

  a_last_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_last |=> m_axis_tvalid_o && m_axis_tlast_o)
    else $error("final word not presented");
`endif

endmodule
